// ----- rtl/core/qfd_pkg.sv -----
// ----------------------------------------------------------------------------
// qfd_pkg
// Shared types and constants for the Q-format to decimal ASCII printer.
// ----------------------------------------------------------------------------
package qfd_pkg;

	// Field widths
	localparam int VALUE_W  = 16;
	localparam int QBITS_W  = 4;
	localparam int CHAR_W   = 7;
	localparam int IPART_W  = 16;          // integer magnitude, up to 32768
	localparam int REM_W    = 15;          // fractional remainder, q <= 15
	localparam int PROD_W   = REM_W + 4;   // remainder times ten
	localparam int DIGIT_W  = 4;
	localparam int BCD_DIGITS = 5;
	localparam int BCD_W    = BCD_DIGITS * DIGIT_W;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_INT,
		ST_DOT,
		ST_FRAC
	} state_t;

endpackage

// ----- rtl/core/qfd_in_if.sv -----
// ----------------------------------------------------------------------------
// qfd_in_if
// Input channel: one signed Q-format number and its fraction bit count.
// ----------------------------------------------------------------------------
interface qfd_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [qfd_pkg::VALUE_W-1:0]  value;
	logic        [qfd_pkg::QBITS_W-1:0]  frac_bits;

	modport source (output valid, output value, output frac_bits, input ready);
	modport sink   (input valid, input value, input frac_bits, output ready);
endinterface

// ----- rtl/core/qfd_out_if.sv -----
// ----------------------------------------------------------------------------
// qfd_out_if
// Output channel: one ASCII character per transaction, with end marker.
// ----------------------------------------------------------------------------
interface qfd_out_if;
	logic                          valid;
	logic                          ready;
	logic [qfd_pkg::CHAR_W-1:0]    char_code;
	logic                          last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- rtl/core/qfd_dabble.sv -----
// ----------------------------------------------------------------------------
// qfd_dabble
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module qfd_dabble (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [qfd_pkg::IPART_W-1:0]   bin,
	output logic                          done,
	output logic [qfd_pkg::BCD_W-1:0]     bcd
);

	localparam int CNT_W = $clog2(qfd_pkg::IPART_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [qfd_pkg::IPART_W-1:0]   sh_q;
	logic [qfd_pkg::BCD_W-1:0]     bcd_q;
	logic [qfd_pkg::BCD_W-1:0]     adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < qfd_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[i*qfd_pkg::DIGIT_W +: qfd_pkg::DIGIT_W] >= 4'd5) begin
				adj[i*qfd_pkg::DIGIT_W +: qfd_pkg::DIGIT_W] =
					bcd_q[i*qfd_pkg::DIGIT_W +: qfd_pkg::DIGIT_W] + 4'd3;
			end else begin
				adj[i*qfd_pkg::DIGIT_W +: qfd_pkg::DIGIT_W] =
					bcd_q[i*qfd_pkg::DIGIT_W +: qfd_pkg::DIGIT_W];
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(qfd_pkg::IPART_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[qfd_pkg::IPART_W-2:0], 1'b0};
			bcd_q <= {adj[qfd_pkg::BCD_W-2:0], sh_q[qfd_pkg::IPART_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ----- rtl/core/qfd_frac_step.sv -----
// ----------------------------------------------------------------------------
// qfd_frac_step
// One fraction digit: remainder times ten, split at the binary point.
// ----------------------------------------------------------------------------
module qfd_frac_step (
	input  logic [qfd_pkg::REM_W-1:0]    rem,
	input  logic [qfd_pkg::QBITS_W-1:0]  q,
	output logic [qfd_pkg::DIGIT_W-1:0]  digit,
	output logic [qfd_pkg::REM_W-1:0]    rem_next
);

	localparam logic [qfd_pkg::REM_W-1:0] REM_W_ONES = '1;

	logic [qfd_pkg::PROD_W-1:0]  prod;
	logic [qfd_pkg::PROD_W-1:0]  shifted;
	logic [qfd_pkg::REM_W-1:0]   mask;

	// x10 as (x << 3) + (x << 1)
	assign prod = {1'b0, rem, 3'b000} + {3'b000, rem, 1'b0};
	assign shifted = prod >> q;
	assign digit = shifted[qfd_pkg::DIGIT_W-1:0];   // below ten since rem < 2^q

	assign mask = REM_W_ONES >> (4'(qfd_pkg::REM_W) - q);
	assign rem_next = prod[qfd_pkg::REM_W-1:0] & mask;

endmodule

// ----- rtl/core/q_format_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// q_format_to_decimal_ascii
// Prints a signed 16-bit Q-format number as decimal ASCII, one character
// per output transaction.
//
//  Channel  Dir  Payload               Handshake
//  num      in   value, frac_bits      valid/ready, taken only when idle
//  chars    out  char_code, last       valid/ready, registered output
//
//  One number at a time. After acceptance the double-dabble unit converts
//  the integer part, then the sequencer prints '-' for a negative number,
//  the five integer digit positions (a dropped leading zero still takes
//  its step), and, if a fraction remains, '.' and the fraction digits,
//  then returns to idle before it takes the next number. Stalls on chars
//  hold the sequencer; the output register keeps its char. Reset clears
//  the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module q_format_to_decimal_ascii #(
	parameter int MAX_CHARS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	qfd_in_if.sink       num,
	qfd_out_if.source    chars
);

	localparam int CNT_W = $clog2(MAX_CHARS + 1);
	localparam int DL_W  = $clog2(qfd_pkg::BCD_DIGITS + 1);

	qfd_pkg::state_t                state_q, state_d;

	logic                           neg_q;
	logic [qfd_pkg::QBITS_W-1:0]    q_q;
	logic [qfd_pkg::REM_W-1:0]      rem_q;
	logic [qfd_pkg::BCD_W-1:0]      bcd_q;
	logic [CNT_W-1:0]               count_q;
	logic [DL_W-1:0]                dig_left_q;
	logic                           lead_q;

	logic                           out_valid_q;
	logic [qfd_pkg::CHAR_W-1:0]     char_q;
	logic                           last_q;

	logic                           accept;
	logic [qfd_pkg::IPART_W:0]      mag;
	logic [qfd_pkg::IPART_W-1:0]    ipart;
	logic [qfd_pkg::REM_W-1:0]      rem_in;
	logic [qfd_pkg::REM_W-1:0]      rem_mask;
	logic                           conv_done;
	logic [qfd_pkg::BCD_W-1:0]      conv_bcd;
	logic [qfd_pkg::DIGIT_W-1:0]    cur_digit;
	logic [qfd_pkg::DIGIT_W-1:0]    frac_digit;
	logic [qfd_pkg::REM_W-1:0]      frac_rem;

	logic                           can_out;
	logic                           emit;
	logic                           skip;
	logic [qfd_pkg::CHAR_W-1:0]     emit_char;
	logic                           emit_last;

	localparam logic [qfd_pkg::REM_W-1:0] REM_ONES = '1;

	// input side
	assign num.ready = (state_q == qfd_pkg::ST_IDLE);
	assign accept    = num.valid && num.ready;

	// magnitude, 17 bits so that -32768 maps to 32768
	assign mag = num.value[qfd_pkg::VALUE_W-1]
		? (17'h10000 - {1'b0, num.value})
		: {1'b0, num.value};
	assign ipart    = qfd_pkg::IPART_W'(mag >> num.frac_bits);
	assign rem_mask = REM_ONES >> (4'(qfd_pkg::REM_W) - num.frac_bits);
	assign rem_in   = mag[qfd_pkg::REM_W-1:0] & rem_mask;

	qfd_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.bin    (ipart),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	qfd_frac_step u_frac (
		.rem      (rem_q),
		.q        (q_q),
		.digit    (frac_digit),
		.rem_next (frac_rem)
	);

	assign cur_digit = bcd_q[qfd_pkg::BCD_W-1 -: qfd_pkg::DIGIT_W];
	assign can_out   = !out_valid_q || chars.ready;

	// sequencer outputs
	always_comb begin
		emit      = 1'b0;
		skip      = 1'b0;
		emit_char = qfd_pkg::CHAR_ZERO;
		emit_last = 1'b0;
		unique case (state_q)
			qfd_pkg::ST_SIGN: begin
				emit      = can_out;
				emit_char = qfd_pkg::CHAR_MINUS;
			end
			qfd_pkg::ST_INT: begin
				skip      = lead_q && (cur_digit == '0) && (dig_left_q != DL_W'(1));
				emit      = can_out && !skip;
				emit_char = qfd_pkg::CHAR_ZERO + {3'b000, cur_digit};
				emit_last = (dig_left_q == DL_W'(1)) && (rem_q == '0);
			end
			qfd_pkg::ST_DOT: begin
				emit      = can_out;
				emit_char = qfd_pkg::CHAR_DOT;
			end
			qfd_pkg::ST_FRAC: begin
				emit      = can_out;
				emit_char = qfd_pkg::CHAR_ZERO + {3'b000, frac_digit};
				emit_last = (frac_rem == '0) || (count_q == CNT_W'(MAX_CHARS - 1));
			end
			default: begin
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qfd_pkg::ST_IDLE: begin
				if (accept) state_d = qfd_pkg::ST_CONV;
			end
			qfd_pkg::ST_CONV: begin
				if (conv_done) state_d = neg_q ? qfd_pkg::ST_SIGN : qfd_pkg::ST_INT;
			end
			qfd_pkg::ST_SIGN: begin
				if (emit) state_d = qfd_pkg::ST_INT;
			end
			qfd_pkg::ST_INT: begin
				if ((emit || skip) && dig_left_q == DL_W'(1)) begin
					state_d = (rem_q != '0) ? qfd_pkg::ST_DOT : qfd_pkg::ST_IDLE;
				end
			end
			qfd_pkg::ST_DOT: begin
				if (emit) state_d = qfd_pkg::ST_FRAC;
			end
			qfd_pkg::ST_FRAC: begin
				if (emit && emit_last) state_d = qfd_pkg::ST_IDLE;
			end
			default: state_d = qfd_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qfd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			dig_left_q  <= '0;
			lead_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				count_q    <= '0;
				dig_left_q <= DL_W'(qfd_pkg::BCD_DIGITS);
				lead_q     <= 1'b1;
			end else begin
				if (emit) count_q <= count_q + 1'b1;
				if (state_q == qfd_pkg::ST_INT && (emit || skip)) begin
					dig_left_q <= dig_left_q - 1'b1;
					if (emit) lead_q <= 1'b0;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= num.value[qfd_pkg::VALUE_W-1];
			q_q   <= num.frac_bits;
			rem_q <= rem_in;
		end else if (state_q == qfd_pkg::ST_FRAC && emit) begin
			rem_q <= frac_rem;
		end
		if (state_q == qfd_pkg::ST_CONV && conv_done) begin
			bcd_q <= conv_bcd;
		end else if (state_q == qfd_pkg::ST_INT && (emit || skip)) begin
			bcd_q <= {bcd_q[qfd_pkg::BCD_W-qfd_pkg::DIGIT_W-1:0], {qfd_pkg::DIGIT_W{1'b0}}};
		end
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign chars.valid     = out_valid_q;
	assign chars.char_code = char_q;
	assign chars.last      = last_q;

endmodule
